// ----- src/fus_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fus_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_DATA  = 3'd2,
    PH_WRITE = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  // Event kinds carried in in_tuser.
  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_FRAME = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  localparam logic [7:0] FT_START = 8'd1;
  localparam logic [7:0] FT_DATA  = 8'd2;
  localparam logic [7:0] FT_END   = 8'd3;

  localparam logic [1:0] ACK_OK  = 2'd0;
  localparam logic [1:0] ACK_ERR = 2'd1;
  localparam logic [1:0] ACK_END = 2'd2;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_META = 2'd1;
  localparam logic [1:0] CMD_PROG = 2'd2;

  localparam logic REG_STORED_VERSION = 1'b0;
  localparam logic REG_ERROR_LIMIT    = 1'b1;

  localparam logic [17:0] META_ADDR     = 18'h0FC00;
  localparam logic [17:0] FW_BASE_ADDR  = 18'h10000;
  localparam logic [10:0] META_LEN      = 11'd4;
  localparam logic [7:0]  ERR_LIMIT_RST = 8'd10;
  localparam logic [7:0]  ERR_CNT_MAX   = 8'hFF;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  frame_type;
    logic        frame_ok;
    logic [15:0] version;
    logic [15:0] fw_size;
    logic [15:0] msg_size;
    logic        write_ok;
  } in_item_t;

  typedef struct packed {
    logic        ack_valid;
    logic [1:0]  ack_code;
    logic [1:0]  flash_cmd;
    logic [17:0] flash_addr;
    logic [10:0] flash_len;
    logic [15:0] meta_version;
    logic [15:0] meta_size;
    logic        reset_request;
    logic        update_done;
  } result_t;

endpackage

`default_nettype wire

// ----- src/firmware_update_frame_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Firmware update frame sequencer. Each input transaction is one event (begin update,
// checked frame, or flash page outcome, selected by in_tuser) and gives at most one
// result transaction carrying the host acknowledge, the flash command and the reset and
// done flags. The block takes one event per cycle while the output is not stalled: an
// event is held in the input register, the sequencing logic updates the state and forms
// the result when the output register is free or being drained, and the output register
// then offers the result. Events that cause no result leave the output untouched.
// Back-pressure on the output stalls the input only when a result is waiting and another
// event is held in the input register behind it. Configuration writes are taken in any
// cycle and must be made only while the block is idle.

module firmware_update_frame_sequencer_top #(
  parameter int PAGE_BYTES = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // frame_type[7:0], frame_ok[8], version[24:9], fw_size[40:25], msg_size[56:41],
  // write_ok[57], zero fill[63:58]
  input  wire logic [63:0] in_tdata,
  // func[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // ack_valid[0], ack_code[2:1], flash_cmd[4:3], flash_addr[22:5], flash_len[33:23],
  // meta_version[49:34], meta_size[65:50], reset_request[66], update_done[67],
  // zero fill[71:68]
  output logic [71:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_data
);

  logic              item_valid;
  fus_pkg::in_item_t item;
  logic              fire;
  logic              res_valid;
  fus_pkg::result_t  res;

  // The sequencing step runs when an event is held and the output register is free or being drained.
  assign fire = item_valid && (!out_tvalid || out_tready);

  fus_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  fus_core #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  fus_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- src/fus_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fus_in_stage (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [fus_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic [1:0]                      in_tuser,
  input  wire logic                            advance,
  output logic                                 item_valid,
  output fus_pkg::in_item_t                    item
);

  logic              valid_r;
  logic              valid_nxt;
  fus_pkg::in_item_t item_r;
  logic              accept;

  assign in_tready = !valid_r || advance;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.func       <= in_tuser;
      item_r.frame_type <= in_tdata[7:0];
      item_r.frame_ok   <= in_tdata[8];
      item_r.version    <= in_tdata[24:9];
      item_r.fw_size    <= in_tdata[40:25];
      item_r.msg_size   <= in_tdata[56:41];
      item_r.write_ok   <= in_tdata[57];
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ----- src/fus_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fus_core #(
  parameter int PAGE_BYTES = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire fus_pkg::in_item_t item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_idx,
  input  wire logic [15:0]       cfg_data,
  output logic                   res_valid,
  output fus_pkg::result_t       res
);

  localparam int PLEN_W = $clog2(PAGE_BYTES + 1);

  fus_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         error_count_r, error_count_nxt;
  logic [17:0]        page_address_r, page_address_nxt;
  logic [16:0]        bytes_done_r, bytes_done_nxt;
  logic [16:0]        total_bytes_r, total_bytes_nxt;
  logic [PLEN_W-1:0]  pending_length_r, pending_length_nxt;
  logic [15:0]        stored_version_r, stored_version_nxt;
  logic [7:0]         error_limit_r;

  logic [7:0]         err_inc;
  logic               timeout;
  logic               do_clear;
  logic               err_event;
  logic [15:0]        start_ver;
  logic               start_good;
  logic [16:0]        remaining;
  logic [16:0]        page_len;
  logic [17:0]        done_sum;

  always_comb begin
    err_inc    = (error_count_r == fus_pkg::ERR_CNT_MAX) ? error_count_r
                                                         : error_count_r + 8'd1;
    timeout    = err_inc > error_limit_r;
    start_ver  = (item.version == 16'd0) ? stored_version_r : item.version;
    start_good = item.frame_ok && (item.frame_type == fus_pkg::FT_START)
                 && (start_ver >= stored_version_r);
    remaining  = total_bytes_r - bytes_done_r;
    page_len   = (remaining < 17'(PAGE_BYTES)) ? remaining : 17'(PAGE_BYTES);
    done_sum   = 18'(bytes_done_r) + 18'(pending_length_r);
  end

  always_comb begin
    phase_nxt          = phase_r;
    error_count_nxt    = error_count_r;
    page_address_nxt   = page_address_r;
    bytes_done_nxt     = bytes_done_r;
    total_bytes_nxt    = total_bytes_r;
    pending_length_nxt = pending_length_r;
    stored_version_nxt = stored_version_r;
    res                = '0;
    res_valid          = 1'b0;
    do_clear           = 1'b0;
    err_event          = 1'b0;

    if (fire) begin
      case (item.func)
        fus_pkg::FUNC_BEGIN: begin
          do_clear = 1'b1;
        end
        fus_pkg::FUNC_FRAME: begin
          case (phase_r)
            fus_pkg::PH_START: begin
              res_valid = 1'b1;
              if (!start_good) begin
                err_event = 1'b1;
              end else begin
                error_count_nxt    = 8'd0;
                stored_version_nxt = start_ver;
                total_bytes_nxt    = 17'(item.fw_size) + 17'(item.msg_size);
                bytes_done_nxt     = 17'd0;
                page_address_nxt   = fus_pkg::FW_BASE_ADDR;
                phase_nxt          = (total_bytes_nxt == 17'd0) ? fus_pkg::PH_END
                                                                : fus_pkg::PH_DATA;
                res.ack_valid      = 1'b1;
                res.ack_code       = fus_pkg::ACK_OK;
                res.flash_cmd      = fus_pkg::CMD_META;
                res.flash_addr     = fus_pkg::META_ADDR;
                res.flash_len      = fus_pkg::META_LEN;
                res.meta_version   = start_ver;
                res.meta_size      = item.fw_size;
              end
            end
            fus_pkg::PH_DATA: begin
              res_valid = 1'b1;
              if (!(item.frame_ok && item.frame_type == fus_pkg::FT_DATA)) begin
                err_event = 1'b1;
              end else begin
                pending_length_nxt = PLEN_W'(page_len);
                phase_nxt          = fus_pkg::PH_WRITE;
                res.flash_cmd      = fus_pkg::CMD_PROG;
                res.flash_addr     = page_address_r;
                res.flash_len      = 11'(page_len);
              end
            end
            fus_pkg::PH_END: begin
              res_valid = 1'b1;
              if (!(item.frame_ok && item.frame_type == fus_pkg::FT_END)) begin
                err_event = 1'b1;
              end else begin
                res.ack_valid   = 1'b1;
                res.ack_code    = fus_pkg::ACK_OK;
                res.update_done = 1'b1;
                do_clear        = 1'b1;
              end
            end
            default: ;
          endcase
        end
        fus_pkg::FUNC_WRITE: begin
          if (phase_r == fus_pkg::PH_WRITE) begin
            res_valid = 1'b1;
            if (item.write_ok) begin
              error_count_nxt    = 8'd0;
              bytes_done_nxt     = (done_sum > 18'(total_bytes_r)) ? total_bytes_r
                                                                   : done_sum[16:0];
              page_address_nxt   = page_address_r + 18'(PAGE_BYTES);
              pending_length_nxt = '0;
              phase_nxt          = (bytes_done_nxt >= total_bytes_r) ? fus_pkg::PH_END
                                                                     : fus_pkg::PH_DATA;
              res.ack_valid      = 1'b1;
              res.ack_code       = fus_pkg::ACK_OK;
            end else begin
              err_event = 1'b1;
              // Unless the error limit is reached, a failed page is programmed again in the same transaction.
              if (!timeout) begin
                res.flash_cmd  = fus_pkg::CMD_PROG;
                res.flash_addr = page_address_r;
                res.flash_len  = 11'(pending_length_r);
              end
            end
          end
        end
        default: ;
      endcase

      if (err_event) begin
        res.ack_valid = 1'b1;
        if (timeout) begin
          res.ack_code      = fus_pkg::ACK_END;
          res.reset_request = 1'b1;
          do_clear          = 1'b1;
        end else begin
          res.ack_code    = fus_pkg::ACK_ERR;
          error_count_nxt = err_inc;
        end
      end

      if (do_clear) begin
        phase_nxt          = fus_pkg::PH_IDLE;
        error_count_nxt    = 8'd0;
        page_address_nxt   = fus_pkg::FW_BASE_ADDR;
        bytes_done_nxt     = 17'd0;
        total_bytes_nxt    = 17'd0;
        pending_length_nxt = '0;
        if (item.func == fus_pkg::FUNC_BEGIN) begin
          phase_nxt = fus_pkg::PH_START;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= fus_pkg::PH_IDLE;
      error_count_r    <= 8'd0;
      page_address_r   <= fus_pkg::FW_BASE_ADDR;
      bytes_done_r     <= 17'd0;
      total_bytes_r    <= 17'd0;
      pending_length_r <= '0;
      stored_version_r <= 16'd0;
      error_limit_r    <= fus_pkg::ERR_LIMIT_RST;
    end else begin
      phase_r          <= phase_nxt;
      error_count_r    <= error_count_nxt;
      page_address_r   <= page_address_nxt;
      bytes_done_r     <= bytes_done_nxt;
      total_bytes_r    <= total_bytes_nxt;
      pending_length_r <= pending_length_nxt;
      stored_version_r <= stored_version_nxt;
      if (cfg_we && cfg_idx == fus_pkg::REG_STORED_VERSION) begin
        stored_version_r <= cfg_data;
      end
      if (cfg_we && cfg_idx == fus_pkg::REG_ERROR_LIMIT) begin
        error_limit_r <= cfg_data[7:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/fus_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fus_out_stage (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             load,
  input  wire fus_pkg::result_t                 res,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [fus_pkg::OUT_DATA_W-1:0]        out_tdata
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic [fus_pkg::OUT_DATA_W-1:0]    data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {4'b0, res.update_done, res.reset_request, res.meta_size,
                 res.meta_version, res.flash_len, res.flash_addr, res.flash_cmd,
                 res.ack_code, res.ack_valid};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

`default_nettype wire

// ----- src/fus_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fus_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // A reset request always travels with an end acknowledge and no flash command.
  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66] |->
      out_tdata[0] && out_tdata[2:1] == fus_pkg::ACK_END
      && out_tdata[4:3] == fus_pkg::CMD_NONE)
    else $error("reset request without end acknowledge");

  // A metadata write always targets the metadata word.
  a_meta_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:3] == fus_pkg::CMD_META |->
      out_tdata[22:5] == fus_pkg::META_ADDR && out_tdata[33:23] == fus_pkg::META_LEN
      && out_tdata[0] && out_tdata[2:1] == fus_pkg::ACK_OK)
    else $error("malformed metadata write");

endmodule

bind firmware_update_frame_sequencer_top fus_checker u_fus_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
